>>> rtl/itoa_pkg.sv
package itoa_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int BITS_PER_STEP   = 4;

    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_SDEC = 3'd1;
    localparam logic [2:0] KIND_UDEC = 3'd2;
    localparam logic [2:0] KIND_HEXL = 3'd3;
    localparam logic [2:0] KIND_HEXU = 3'd4;

    localparam logic [1:0] EMIT_SIGN  = 2'd0;
    localparam logic [1:0] EMIT_DIGIT = 2'd1;
    localparam logic [1:0] EMIT_CHAR  = 2'd2;

    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPPER = 8'h41;
    localparam logic [7:0] ASCII_LOWER = 8'h61;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       find;
        logic       emit;
        logic [1:0] emit_sel;
    } itoa_cmd_t;

    typedef struct packed {
        logic neg;
        logic idx_zero;
    } itoa_sts_t;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] d8;
        d8 = {4'h0, d};
        if (d < 4'd10) begin
            return ASCII_ZERO + d8;
        end
        return (upper ? ASCII_UPPER : ASCII_LOWER) + d8 - 8'd10;
    endfunction

endpackage

>>> rtl/integer_to_ascii_formatter.sv
// Decimal kinds: accept, BCD conversion four bits per step, find the leading digit,
// then one character per cycle while the output register is free (up to 11 at 32 bits).
// Hex kinds skip the conversion; char kind emits a single character.
// Next item is taken once the last character is in the output register.
// aresetn is synchronous and active low; it clears the sequencer and the output valid.
module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_WIDTH-1:0] s_tdata,  // value
    input  logic [2:0]            s_tuser,  // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // ascii_char
    output logic                  m_tlast
);

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    itoa_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    itoa_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .value      (s_tdata[VALUE_WIDTH-1:0]),
        .req_type   (s_tuser),
        .cmd        (cmd),
        .sts        (sts),
        .ascii_char (m_tdata),
        .last_char  (m_tlast)
    );

endmodule

>>> rtl/itoa_ctrl.sv
module itoa_ctrl
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [2:0] s_tuser,
    input  logic       m_tready,
    input  itoa_sts_t  sts,
    output logic       s_tready,
    output logic       m_tvalid,
    output itoa_cmd_t  cmd
);

    localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int CW    = $clog2(STEPS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_FIND  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;
    localparam logic [2:0] ST_CHAR  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic          slot_free;

    assign slot_free = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = CW'(STEPS - 1);
                    unique case (s_tuser) inside
                        KIND_SDEC, KIND_UDEC: state_next = ST_CONV;
                        KIND_HEXL, KIND_HEXU: state_next = ST_FIND;
                        KIND_CHAR:            state_next = ST_CHAR;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIND;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = sts.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (slot_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_SIGN;
                    m_valid_next = 1'b1;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (slot_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_DIGIT;
                    m_valid_next = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHAR: begin
                if (slot_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_CHAR;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !cmd.emit)
        else $error("pending item overwritten");

    a_conv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && cnt_reg == '0) |=> (state_reg == ST_FIND))
        else $error("conversion did not finish on time");

    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_sel == EMIT_DIGIT && sts.idx_zero) |=> (state_reg == ST_IDLE))
        else $error("digits continued past the last one");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.emit))
        else $error("output valid without an emit");
`endif

endmodule

>>> rtl/itoa_dp.sv
module itoa_dp
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [2:0]             req_type,
    input  itoa_cmd_t              cmd,
    output itoa_sts_t              sts,
    output logic [7:0]             ascii_char,
    output logic                   last_char
);

    localparam int STEPS      = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PW         = STEPS * BITS_PER_STEP;
    localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BW         = NUM_DIGITS * 4;
    localparam int IW         = $clog2(NUM_DIGITS);

    logic [PW-1:0]                src_reg;
    logic [NUM_DIGITS-1:0][3:0]   bcd_reg;
    logic [IW-1:0]                idx_reg;
    logic                         neg_reg;
    logic                         upper_reg;
    logic [7:0]                   char_reg;
    logic                         last_reg;

    logic                         load_neg;
    logic [VALUE_WIDTH-1:0]       load_mag;
    logic [BW-1:0]                step_bcd;
    logic [PW-1:0]                step_src;
    logic [IW-1:0]                find_idx;
    logic [3:0]                   cur_digit;
    logic [7:0]                   emit_char;

    assign load_neg = (req_type == KIND_SDEC) && value[VALUE_WIDTH-1];
    assign load_mag = load_neg ? (~value + 1'b1) : value;

    // four shift-add-3 passes per cycle
    always_comb begin
        step_bcd = bcd_reg;
        step_src = src_reg;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (step_bcd[d*4 +: 4] >= 4'd5) begin
                    step_bcd[d*4 +: 4] = step_bcd[d*4 +: 4] + 4'd3;
                end
            end
            step_bcd = {step_bcd[BW-2:0], step_src[PW-1]};
            step_src = {step_src[PW-2:0], 1'b0};
        end
    end

    always_comb begin
        find_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[d] != 4'h0) begin
                find_idx = IW'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg];

    always_comb begin
        unique case (cmd.emit_sel)
            EMIT_SIGN:  emit_char = ASCII_MINUS;
            EMIT_DIGIT: emit_char = digit_ascii(cur_digit, upper_reg);
            EMIT_CHAR:  emit_char = src_reg[7:0];
            default:    emit_char = ASCII_ZERO;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            src_reg   <= PW'(load_mag);
            neg_reg   <= load_neg;
            upper_reg <= (req_type == KIND_HEXU);
            if (req_type == KIND_HEXL || req_type == KIND_HEXU) begin
                bcd_reg <= BW'(value);
            end else begin
                bcd_reg <= '0;
            end
        end else if (cmd.step) begin
            src_reg <= step_src;
            bcd_reg <= step_bcd;
        end
        if (cmd.find) begin
            idx_reg <= find_idx;
        end else if (cmd.emit && cmd.emit_sel == EMIT_DIGIT) begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.emit) begin
            char_reg <= emit_char;
            last_reg <= (cmd.emit_sel == EMIT_CHAR) ||
                        (cmd.emit_sel == EMIT_DIGIT && idx_reg == '0);
        end
    end

    assign sts.neg      = neg_reg;
    assign sts.idx_zero = (idx_reg == '0);
    assign ascii_char   = char_reg;
    assign last_char    = last_reg;

endmodule

>>> tb/sv/itoa_checker.sv
module itoa_checker
    import itoa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [2:0]  s_tuser,   // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // ascii_char
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          chars_pending
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    char_item_t pending_chars[$];

    function automatic logic [7:0] digit_code(input int d, input bit upper);
        if (d < 10) begin
            return ASCII_ZERO + 8'(d);
        end
        return (upper ? ASCII_UPPER : ASCII_LOWER) + 8'(d - 10);
    endfunction

    // Queues the characters one request should produce, leading digit first.
    function automatic void format_value(input logic [2:0] kind, input logic [31:0] val);
        logic [7:0] digs [0:31];
        logic [31:0] mag;
        int base;
        int n;
        bit upper;
        bit neg;
        mag = val;
        upper = 1'b0;
        neg = 1'b0;
        base = 10;
        case (kind)
            KIND_CHAR: begin
                pending_chars.push_back('{code: val[7:0], last: 1'b1});
                return;
            end
            KIND_SDEC: begin
                neg = val[31];
                if (neg) begin
                    mag = ~val + 32'd1;
                end
            end
            KIND_UDEC: base = 10;
            KIND_HEXL: base = 16;
            KIND_HEXU: begin
                base = 16;
                upper = 1'b1;
            end
            default: return;
        endcase
        n = 0;
        do begin
            digs[n] = digit_code(int'(mag % base), upper);
            n++;
            mag = mag / base;
        end while (mag != 0);
        if (neg) begin
            pending_chars.push_back('{code: ASCII_MINUS, last: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            pending_chars.push_back('{code: digs[i], last: (i == 0)});
        end
    endfunction

    always @(posedge aclk) begin
        char_item_t exp_c;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected char got %h last %b", $time, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    exp_c = pending_chars.pop_front();
                    if (m_tdata !== exp_c.code || m_tlast !== exp_c.last) begin
                        $display("%0t: char mismatch expected %h last %b, got %h last %b",
                                 $time, exp_c.code, exp_c.last, m_tdata, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                format_value(s_tuser, s_tdata);
            end
        end
        chars_pending <= pending_chars.size();
    end

endmodule

>>> tb/sv/testbench.sv
module testbench
    import itoa_pkg::*;
();

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 62;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // value
    logic [2:0]  s_tuser = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // ascii_char
    logic        m_tlast;

    int mismatch_count;
    int chars_pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_id = 0;
    bit stim_done = 1'b0;
    int quiet_cycles = 0;

    integer_to_ascii_formatter uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    itoa_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .chars_pending (chars_pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int seen;
        int hold_left;
        seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_id != seen) begin
                seen = hold_id;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (stim_done && chars_pending == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] p10;
        int e;
        case ($urandom_range(7))
            0: return $urandom_range(20);
            1: return 32'h8000_0000 + $urandom_range(3) - 32'd1;
            2: return 32'hFFFF_FFFF - $urandom_range(12);
            3: begin
                p10 = 32'd1;
                e = $urandom_range(9);
                repeat (e) p10 = p10 * 10;
                return p10 + $urandom_range(2) - 32'd1;
            end
            4: return (32'd1 << (4 * $urandom_range(7))) + $urandom_range(2) - 32'd1;
            5: return $urandom_range(65535);
            default: return $urandom();
        endcase
    endfunction

    task automatic run_random(input int count);
        logic [2:0] kind;
        int done_cnt;
        done_cnt = 0;
        while (done_cnt < count) begin
            if ($urandom_range(19) == 0) begin
                kind = 3'(5 + $urandom_range(2));
            end else begin
                kind = 3'($urandom_range(4));
                done_cnt++;
            end
            send_item(kind, pick_value());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(KIND_CHAR, 32'h0000_0000);
        send_item(KIND_CHAR, 32'h0000_00FF);
        send_item(KIND_CHAR, 32'h1234_5641);
        send_item(KIND_SDEC, 32'h0000_0000);
        send_item(KIND_SDEC, 32'h8000_0000);
        send_item(KIND_SDEC, 32'h7FFF_FFFF);
        send_item(KIND_SDEC, 32'hFFFF_FFFF);
        send_item(KIND_SDEC, 32'hFFFF_FFF6);
        send_item(KIND_SDEC, 32'd9);
        send_item(KIND_SDEC, 32'd10);
        send_item(KIND_UDEC, 32'h0000_0000);
        send_item(KIND_UDEC, 32'hFFFF_FFFF);
        send_item(KIND_UDEC, 32'd1000000000);
        send_item(KIND_HEXL, 32'h0000_0000);
        send_item(KIND_HEXL, 32'hDEAD_BEEF);
        send_item(KIND_HEXL, 32'hFFFF_FFFF);
        send_item(KIND_HEXU, 32'hABCD_EF01);
        send_item(KIND_HEXU, 32'h0000_0010);
        send_item(KIND_HEXU, 32'h0000_0000);
        send_item(3'd5, 32'h1234_5678);
        send_item(3'd6, 32'hFFFF_FFFF);
        send_item(3'd7, 32'h0000_0000);
        send_item(KIND_HEXU, 32'hFFFF_FFFF);

        // long hold-off on the result side while items keep coming
        hold_id <= hold_id + 1;
        run_random(PHASE_ITEMS);

        send_idle_pct = 75;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_stall_pct = 75;
        run_random(PHASE_ITEMS);

        send_idle_pct = 27;
        recv_stall_pct = 27;
        run_random(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
